// File: rtl/tlcc_pkg.sv
`default_nettype none

package tlcc_pkg;

   localparam int COORD_BITS = 12;
   localparam int DIST_BITS = 25;
   localparam int CSR_DATA_BITS = (DIST_BITS > COORD_BITS) ? DIST_BITS : COORD_BITS;
   localparam int CSR_INDEX_BITS = 3;

   localparam int COEF_AB_BITS = COORD_BITS + 1;
   localparam int COEF_C_BITS = 2 * COORD_BITS + 1;
   localparam int PROD_BITS = 2 * COORD_BITS + 2;
   localparam int VAL_BITS = 2 * COORD_BITS + 4;
   localparam int D2_BITS = 2 * COORD_BITS + 1;
   localparam int CMP_BITS = (D2_BITS > DIST_BITS) ? D2_BITS : DIST_BITS;

   localparam logic [DIST_BITS-1:0] MIN_DIST_RESET = DIST_BITS'(400);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LINE_HEAD_X = 3'd0,
      CSR_LINE_HEAD_Y = 3'd1,
      CSR_LINE_TAIL_X = 3'd2,
      CSR_LINE_TAIL_Y = 3'd3,
      CSR_MIN_DIST_SQUARED = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      CROSS_NONE = 2'd0,
      CROSS_OUT = 2'd1,
      CROSS_IN = 2'd2
   } crossing_type;

endpackage

`default_nettype wire

// File: rtl/trajectory_line_crossing_classifier_core.sv
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_start_x, req_start_y, req_stop_x, req_stop_y
// rsp       out        rsp_valid/stall    rsp_crossing
// csr       in         csr_we             csr_index, csr_wdata
//
// One item per cycle while rsp does not stall; an item accepted on req goes through the input
// register and the result register, with the side and length products in between; line
// coefficients come from a register.
// Reset is synchronous; it clears the valid flags and the line points and sets the
// threshold to 400.
// A stall on rsp holds the result item; req stalls once the input register is full as well.

`default_nettype none

module trajectory_line_crossing_classifier_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [tlcc_pkg::COORD_BITS-1:0]       req_start_x,
   input  wire logic [tlcc_pkg::COORD_BITS-1:0]       req_start_y,
   input  wire logic [tlcc_pkg::COORD_BITS-1:0]       req_stop_x,
   input  wire logic [tlcc_pkg::COORD_BITS-1:0]       req_stop_y,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [1:0]                                 rsp_crossing,
   input  wire logic                                  csr_we,
   input  wire logic [tlcc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [tlcc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   logic [tlcc_pkg::COORD_BITS-1:0] head_x_ff, head_y_ff, tail_x_ff, tail_y_ff;
   logic [tlcc_pkg::DIST_BITS-1:0] min_dist_ff;

   logic signed [tlcc_pkg::COEF_AB_BITS-1:0] coef_a_ff, coef_a_in;
   logic signed [tlcc_pkg::COEF_AB_BITS-1:0] coef_b_ff, coef_b_in;
   logic signed [tlcc_pkg::COEF_C_BITS-1:0] coef_c_ff, coef_c_in;
   logic [2*tlcc_pkg::COORD_BITS-1:0] prod_th, prod_ht;

   logic s1_valid_ff;
   logic [tlcc_pkg::COORD_BITS-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic rsp_valid_ff;
   tlcc_pkg::crossing_type crossing_ff, crossing_in;

   logic s1_load, s2_load;

   logic signed [tlcc_pkg::PROD_BITS-1:0] ax_s, by_s, ax_e, by_e;
   logic signed [tlcc_pkg::VAL_BITS-1:0] val_s, val_e;
   logic signed [tlcc_pkg::COORD_BITS:0] dx, dy;
   logic [2*tlcc_pkg::COORD_BITS-1:0] dx_sq, dy_sq;
   logic [tlcc_pkg::D2_BITS-1:0] d2;
   logic same_side, too_short;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_x_ff <= '0;
         head_y_ff <= '0;
         tail_x_ff <= '0;
         tail_y_ff <= '0;
         min_dist_ff <= tlcc_pkg::MIN_DIST_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tlcc_pkg::CSR_LINE_HEAD_X: head_x_ff <= csr_wdata[tlcc_pkg::COORD_BITS-1:0];
            tlcc_pkg::CSR_LINE_HEAD_Y: head_y_ff <= csr_wdata[tlcc_pkg::COORD_BITS-1:0];
            tlcc_pkg::CSR_LINE_TAIL_X: tail_x_ff <= csr_wdata[tlcc_pkg::COORD_BITS-1:0];
            tlcc_pkg::CSR_LINE_TAIL_Y: tail_y_ff <= csr_wdata[tlcc_pkg::COORD_BITS-1:0];
            tlcc_pkg::CSR_MIN_DIST_SQUARED: begin
               min_dist_ff <= csr_wdata[tlcc_pkg::DIST_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The line coefficients are registered from the line points and follow them in the next cycle.
   always_comb begin
      coef_a_in = $signed({1'b0, tail_y_ff}) - $signed({1'b0, head_y_ff});
      coef_b_in = $signed({1'b0, head_x_ff}) - $signed({1'b0, tail_x_ff});
      prod_th = tail_x_ff * head_y_ff;
      prod_ht = head_x_ff * tail_y_ff;
      coef_c_in = $signed({1'b0, prod_th}) - $signed({1'b0, prod_ht});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= '0;
      end else begin
         coef_a_ff <= coef_a_in;
         coef_b_ff <= coef_b_in;
         coef_c_ff <= coef_c_in;
      end
   end

   assign s2_load = !rsp_valid_ff || !rsp_stall;
   assign s1_load = !s1_valid_ff || s2_load;
   assign req_stall = !s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_load) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         sx_ff <= req_start_x;
         sy_ff <= req_start_y;
         ex_ff <= req_stop_x;
         ey_ff <= req_stop_y;
      end
      if (s2_load && s1_valid_ff) begin
         crossing_ff <= crossing_in;
      end
   end

   always_comb begin
      ax_s = coef_a_ff * $signed({1'b0, sx_ff});
      by_s = coef_b_ff * $signed({1'b0, sy_ff});
      ax_e = coef_a_ff * $signed({1'b0, ex_ff});
      by_e = coef_b_ff * $signed({1'b0, ey_ff});
      val_s = tlcc_pkg::VAL_BITS'(ax_s) + tlcc_pkg::VAL_BITS'(by_s)
            + tlcc_pkg::VAL_BITS'(coef_c_ff);
      val_e = tlcc_pkg::VAL_BITS'(ax_e) + tlcc_pkg::VAL_BITS'(by_e)
            + tlcc_pkg::VAL_BITS'(coef_c_ff);
      same_side = ((val_s > 0) && (val_e > 0)) || ((val_s < 0) && (val_e < 0));

      dx = $signed({1'b0, sx_ff}) - $signed({1'b0, ex_ff});
      dy = $signed({1'b0, sy_ff}) - $signed({1'b0, ey_ff});
      dx_sq = dx * dx;
      dy_sq = dy * dy;
      d2 = tlcc_pkg::D2_BITS'(dx_sq) + tlcc_pkg::D2_BITS'(dy_sq);
      too_short = tlcc_pkg::CMP_BITS'(d2) <= tlcc_pkg::CMP_BITS'(min_dist_ff);

      if (same_side || too_short) begin
         crossing_in = tlcc_pkg::CROSS_NONE;
      end else if (ey_ff < sy_ff) begin
         crossing_in = tlcc_pkg::CROSS_OUT;
      end else begin
         crossing_in = tlcc_pkg::CROSS_IN;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_crossing = crossing_ff;

`ifndef SYNTH
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted item did not reach the input register");

   a_s1_moves_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_load) |=> rsp_valid_ff)
      else $error("item in the input register was lost");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("req stalled while the pipeline had room");

   a_s1_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_load) |=> (s1_valid_ff && $stable(sx_ff) && $stable(ey_ff)))
      else $error("input register changed while the result was stalled");
`endif

endmodule

`default_nettype wire
